// ===== src/owned_id_pool_allocator_defines.svh =====
// ---------------------------------------------------------------------------
// owned id pool allocator assertion macros
// shared property forms for the allocator's checks, clocked by clock and
// disabled during reset
// ---------------------------------------------------------------------------
`ifndef OWNED_ID_POOL_ALLOCATOR_DEFINES_SVH
`define OWNED_ID_POOL_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define OIPA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OIPA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/oipa_pkg.sv =====
// ---------------------------------------------------------------------------
// oipa_pkg
// shared widths, command and status codes, and the controller/datapath
// command and status structs of the owned id pool allocator
// ---------------------------------------------------------------------------
package oipa_pkg;

   localparam int DEF_MAX_IDS    = 16;
   localparam int DEF_NUM_OWNERS = 16;
   localparam int LIST_LIMIT     = 16;

   localparam int CMD_W    = 4;
   localparam int OWNER_W  = 4;
   localparam int ID_W     = 4;
   localparam int NEED_W   = 5;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_CAN_ACCEPT    = 4'd0;
   localparam logic [CMD_W-1:0] CMD_CLOSE         = 4'd1;
   localparam logic [CMD_W-1:0] CMD_OPEN          = 4'd2;
   localparam logic [CMD_W-1:0] CMD_RESERVE_OWNED = 4'd3;
   localparam logic [CMD_W-1:0] CMD_RELEASE_OWNER = 4'd4;
   localparam logic [CMD_W-1:0] CMD_LIST_OWNER    = 4'd5;
   localparam logic [CMD_W-1:0] CMD_ANY_FREE      = 4'd6;
   localparam logic [CMD_W-1:0] CMD_RESERVE_PLAIN = 4'd7;
   localparam logic [CMD_W-1:0] CMD_GIVE_BACK     = 4'd8;
   localparam logic [CMD_W-1:0] CMD_IS_FREE       = 4'd9;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic rd_head;
      logic do_query;
      logic do_close;
      logic do_open;
      logic do_res_owned;
      logic do_res_plain;
      logic do_give_back;
      logic load_rel;
      logic load_lst;
      logic load_scn;
      logic rd_rel;
      logic rel_push;
      logic rd_lst;
      logic emit_list;
      logic rd_scn;
      logic cmp_scn;
      logic emit_acc;
   } oipa_ctl_type;

   // datapath to controller
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             at_bound;
      logic             idx_zero;
      logic             idx_last;
   } oipa_stat_type;

endpackage

// ===== src/oipa_ram.sv =====
// ---------------------------------------------------------------------------
// oipa_ram
// generic single write port, single read port ram with registered read data
// ---------------------------------------------------------------------------
module oipa_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/oipa_ctrl.sv =====
// ---------------------------------------------------------------------------
// oipa_ctrl
// command sequencer: decodes each item and steps the datapath through
// fetch, execute, list, release and membership scan loops
// ---------------------------------------------------------------------------
module oipa_ctrl
   import oipa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output oipa_ctl_type  ctl,
   input  oipa_stat_type stat
);

`include "owned_id_pool_allocator_defines.svh"

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_FETCH    = 4'd1;
   localparam logic [3:0] S_EXEC     = 4'd2;
   localparam logic [3:0] S_REL_CHK  = 4'd3;
   localparam logic [3:0] S_REL_PUSH = 4'd4;
   localparam logic [3:0] S_LST_RD   = 4'd5;
   localparam logic [3:0] S_LST_OUT  = 4'd6;
   localparam logic [3:0] S_SCN_RD   = 4'd7;
   localparam logic [3:0] S_SCN_CMP  = 4'd8;
   localparam logic [3:0] S_RESP     = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.capture = 1'b1;
               state_in    = S_FETCH;
            end
         end
         S_FETCH: begin
            ctl.rd_head = 1'b1;
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
            case (stat.cmd)
               CMD_CAN_ACCEPT:    ctl.do_query     = 1'b1;
               CMD_ANY_FREE:      ctl.do_query     = 1'b1;
               CMD_CLOSE:         ctl.do_close     = 1'b1;
               CMD_OPEN:          ctl.do_open      = 1'b1;
               CMD_RESERVE_OWNED: ctl.do_res_owned = 1'b1;
               CMD_RESERVE_PLAIN: ctl.do_res_plain = 1'b1;
               CMD_GIVE_BACK:     ctl.do_give_back = 1'b1;
               CMD_RELEASE_OWNER: begin
                  ctl.load_rel = 1'b1;
                  state_in     = S_REL_CHK;
               end
               CMD_LIST_OWNER: begin
                  ctl.load_lst = 1'b1;
                  state_in     = S_LST_RD;
               end
               CMD_IS_FREE: begin
                  ctl.load_scn = 1'b1;
                  state_in     = S_SCN_RD;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_REL_CHK: begin
            if (stat.idx_zero) begin
               state_in = S_RESP;
            end else begin
               ctl.rd_rel = 1'b1;
               state_in   = S_REL_PUSH;
            end
         end
         S_REL_PUSH: begin
            ctl.rel_push = 1'b1;
            state_in     = S_REL_CHK;
         end
         S_LST_RD: begin
            if (stat.at_bound) begin
               state_in = S_RESP;
            end else begin
               ctl.rd_lst = 1'b1;
               state_in   = S_LST_OUT;
            end
         end
         S_LST_OUT: begin
            ctl.emit_list = 1'b1;
            state_in      = stat.idx_last ? S_IDLE : S_LST_RD;
         end
         S_SCN_RD: begin
            if (stat.at_bound) begin
               state_in = S_RESP;
            end else begin
               ctl.rd_scn = 1'b1;
               state_in   = S_SCN_CMP;
            end
         end
         S_SCN_CMP: begin
            ctl.cmp_scn = 1'b1;
            state_in    = S_SCN_RD;
         end
         S_RESP: begin
            ctl.emit_acc = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   `OIPA_ASSERT_NEXT(a_accept_fetch, start && !busy, state_ff == S_FETCH,
      "accepted item did not enter fetch")
   `OIPA_ASSERT_NEXT(a_single_ends, ctl.emit_acc, state_ff == S_IDLE,
      "single result did not end the item")

endmodule

// ===== src/oipa_dp.sv =====
// ---------------------------------------------------------------------------
// oipa_dp
// datapath: free ring, owner id lists and lengths, loop counter, result
// accumulator and the registered result port
// ---------------------------------------------------------------------------
module oipa_dp
   import oipa_pkg::*;
#(
   parameter int MAX_IDS    = DEF_MAX_IDS,
   parameter int NUM_OWNERS = DEF_NUM_OWNERS
) (
   input  logic                clock,
   input  logic                reset,
   input  oipa_ctl_type        ctl,
   output oipa_stat_type       stat,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [OWNER_W-1:0]  req_owner,
   input  logic [ID_W-1:0]     req_id_in,
   input  logic [NEED_W-1:0]   req_needed_count,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_answer,
   output logic [ID_W-1:0]     rsp_id_out,
   output logic                rsp_id_valid,
   output logic                rsp_last
);

`include "owned_id_pool_allocator_defines.svh"

   localparam int RING_AW = $clog2(MAX_IDS);
   localparam int CNT_W   = $clog2(MAX_IDS + 1);
   localparam int SUM_W   = CNT_W + 1;
   localparam int OWN_AW  = $clog2(NUM_OWNERS);
   localparam int OIDS_AW = $clog2(NUM_OWNERS * MAX_IDS);

   function automatic logic [RING_AW-1:0] ring_pos(input logic [RING_AW-1:0] base,
                                                   input logic [CNT_W-1:0]   off);
      logic [SUM_W-1:0] s;
      s = SUM_W'(base) + SUM_W'(off);
      if (s >= SUM_W'(MAX_IDS)) begin
         s = s - SUM_W'(MAX_IDS);
      end
      return s[RING_AW-1:0];
   endfunction

   // captured item
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [OWNER_W-1:0]  owner_ff, owner_in;
   logic [ID_W-1:0]     idin_ff, idin_in;
   logic [NEED_W-1:0]   need_ff, need_in;
   // pool state
   logic [RING_AW-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                open_ff, open_in;
   logic [MAX_IDS-1:0]  ring_vld_ff, ring_vld_in;
   logic [NUM_OWNERS-1:0] len_vld_ff, len_vld_in;
   // read side tags
   logic [RING_AW-1:0]  ring_aq_ff, ring_aq_in;
   logic                ring_vq_ff, ring_vq_in;
   logic                len_vq_ff, len_vq_in;
   // loop
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    bound_ff, bound_in;
   // accumulated single result
   logic [STATUS_W-1:0] st_ff, st_in;
   logic                ans_ff, ans_in;
   logic [ID_W-1:0]     oid_ff, oid_in;
   logic                oidv_ff, oidv_in;
   // result port
   logic                rsp_vld_ff, rsp_vld_in;
   logic [STATUS_W-1:0] rsp_st_ff, rsp_st_in;
   logic                rsp_ans_ff, rsp_ans_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic                rsp_idv_ff, rsp_idv_in;
   logic                rsp_last_ff, rsp_last_in;

   // ram ports
   logic                ring_we, ring_re;
   logic [RING_AW-1:0]  ring_wa, ring_ra;
   logic [ID_W-1:0]     ring_wd, ring_rd;
   logic                ids_we, ids_re;
   logic [OIDS_AW-1:0]  ids_wa, ids_ra;
   logic [ID_W-1:0]     ids_rd;
   logic                len_we, len_re;
   logic [CNT_W-1:0]    len_wd, len_rd;

   logic [OWN_AW-1:0]   own_idx;
   logic                own_ok;
   logic [ID_W-1:0]     ring_data;
   logic [CNT_W-1:0]    len_q;
   logic [RING_AW-1:0]  head_next, head_prev;
   logic                ring_has_room;
   logic [CNT_W-1:0]    ids_slot;

   assign own_idx       = OWN_AW'(owner_ff);
   assign own_ok        = int'(owner_ff) < NUM_OWNERS;
   assign ring_data     = ring_vq_ff ? ring_rd : ID_W'(ring_aq_ff);
   assign len_q         = len_vq_ff ? len_rd : '0;
   assign head_next     = (head_ff == RING_AW'(MAX_IDS - 1)) ? '0 : head_ff + RING_AW'(1);
   assign head_prev     = (head_ff == '0) ? RING_AW'(MAX_IDS - 1) : head_ff - RING_AW'(1);
   assign ring_has_room = count_ff < CNT_W'(MAX_IDS);
   assign ids_slot      = ctl.rd_rel ? idx_ff - CNT_W'(1) : idx_ff;

   always_comb begin
      cmd_in      = cmd_ff;
      owner_in    = owner_ff;
      idin_in     = idin_ff;
      need_in     = need_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      open_in     = open_ff;
      ring_vld_in = ring_vld_ff;
      len_vld_in  = len_vld_ff;
      idx_in      = idx_ff;
      bound_in    = bound_ff;
      st_in       = st_ff;
      ans_in      = ans_ff;
      oid_in      = oid_ff;
      oidv_in     = oidv_ff;
      ring_we     = 1'b0;
      ring_wa     = head_prev;
      ring_wd     = ids_rd;
      ids_we      = 1'b0;
      ids_wa      = OIDS_AW'(own_idx) * OIDS_AW'(MAX_IDS) + OIDS_AW'(len_q);
      len_we      = 1'b0;
      len_wd      = len_q + CNT_W'(1);

      if (ctl.capture) begin
         cmd_in   = req_command;
         owner_in = req_owner;
         idin_in  = req_id_in;
         need_in  = req_needed_count;
         st_in    = ST_OK;
         ans_in   = 1'b0;
         oid_in   = '0;
         oidv_in  = 1'b0;
      end
      if (ctl.do_query) begin
         if (cmd_ff == CMD_CAN_ACCEPT) begin
            ans_in = open_ff && (int'(count_ff) >= int'(need_ff));
         end else begin
            ans_in = (count_ff != '0);
         end
      end
      if (ctl.do_close) begin
         open_in = 1'b0;
      end
      if (ctl.do_open) begin
         open_in = 1'b1;
      end
      if (ctl.do_res_owned) begin
         if (!own_ok || len_q >= CNT_W'(MAX_IDS) || count_ff == '0) begin
            st_in = ST_EMPTY;
         end else begin
            head_in             = head_next;
            count_in            = count_ff - CNT_W'(1);
            ids_we              = 1'b1;
            len_we              = 1'b1;
            len_vld_in[own_idx] = 1'b1;
            oid_in              = ring_data;
            oidv_in             = 1'b1;
         end
      end
      if (ctl.do_res_plain) begin
         if (count_ff == '0) begin
            st_in = ST_EMPTY;
         end else begin
            head_in  = head_next;
            count_in = count_ff - CNT_W'(1);
            oid_in   = ring_data;
            oidv_in  = 1'b1;
         end
      end
      if (ctl.do_give_back) begin
         if (ring_has_room) begin
            ring_we              = 1'b1;
            ring_wa              = ring_pos(head_ff, count_ff);
            ring_wd              = idin_ff;
            ring_vld_in[ring_wa] = 1'b1;
            count_in             = count_ff + CNT_W'(1);
         end else begin
            st_in = ST_FULL;
         end
      end
      if (ctl.load_rel) begin
         idx_in = own_ok ? len_q : '0;
         if (own_ok) begin
            len_vld_in[own_idx] = 1'b0;
         end
      end
      if (ctl.load_lst) begin
         idx_in = '0;
         if (!own_ok) begin
            bound_in = '0;
         end else if (int'(len_q) > LIST_LIMIT) begin
            bound_in = CNT_W'(LIST_LIMIT);
         end else begin
            bound_in = len_q;
         end
      end
      if (ctl.load_scn) begin
         idx_in   = '0;
         bound_in = count_ff;
      end
      if (ctl.rel_push) begin
         idx_in = idx_ff - CNT_W'(1);
         if (ring_has_room) begin
            ring_we              = 1'b1;
            ring_wa              = head_prev;
            ring_wd              = ids_rd;
            ring_vld_in[ring_wa] = 1'b1;
            head_in              = head_prev;
            count_in             = count_ff + CNT_W'(1);
         end else begin
            st_in = ST_FULL;
         end
      end
      if (ctl.emit_list) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (ctl.cmp_scn) begin
         idx_in = idx_ff + CNT_W'(1);
         if (ring_data == idin_ff) begin
            ans_in = 1'b1;
         end
      end
   end

   // read port selection and read tags
   always_comb begin
      ring_re    = ctl.rd_head || ctl.rd_scn;
      ring_ra    = ctl.rd_scn ? ring_pos(head_ff, idx_ff) : head_ff;
      ring_aq_in = ring_re ? ring_ra : ring_aq_ff;
      ring_vq_in = ring_re ? ring_vld_ff[ring_ra] : ring_vq_ff;
      len_re     = ctl.rd_head;
      len_vq_in  = len_re ? len_vld_ff[own_idx] : len_vq_ff;
      ids_re     = ctl.rd_rel || ctl.rd_lst;
      ids_ra     = OIDS_AW'(own_idx) * OIDS_AW'(MAX_IDS) + OIDS_AW'(ids_slot);
   end

   // result port
   always_comb begin
      rsp_vld_in  = ctl.emit_acc || ctl.emit_list;
      rsp_st_in   = rsp_st_ff;
      rsp_ans_in  = rsp_ans_ff;
      rsp_id_in   = rsp_id_ff;
      rsp_idv_in  = rsp_idv_ff;
      rsp_last_in = rsp_last_ff;
      if (ctl.emit_acc) begin
         rsp_st_in   = st_ff;
         rsp_ans_in  = ans_ff;
         rsp_id_in   = oid_ff;
         rsp_idv_in  = oidv_ff;
         rsp_last_in = 1'b1;
      end else if (ctl.emit_list) begin
         rsp_st_in   = ST_OK;
         rsp_ans_in  = 1'b0;
         rsp_id_in   = ids_rd;
         rsp_idv_in  = 1'b1;
         rsp_last_in = stat.idx_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         count_ff    <= CNT_W'(MAX_IDS);
         open_ff     <= 1'b1;
         ring_vld_ff <= '0;
         len_vld_ff  <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         head_ff     <= head_in;
         count_ff    <= count_in;
         open_ff     <= open_in;
         ring_vld_ff <= ring_vld_in;
         len_vld_ff  <= len_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      owner_ff    <= owner_in;
      idin_ff     <= idin_in;
      need_ff     <= need_in;
      ring_aq_ff  <= ring_aq_in;
      ring_vq_ff  <= ring_vq_in;
      len_vq_ff   <= len_vq_in;
      idx_ff      <= idx_in;
      bound_ff    <= bound_in;
      st_ff       <= st_in;
      ans_ff      <= ans_in;
      oid_ff      <= oid_in;
      oidv_ff     <= oidv_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_ans_ff  <= rsp_ans_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_idv_ff  <= rsp_idv_in;
      rsp_last_ff <= rsp_last_in;
   end

   oipa_ram #(.WIDTH(ID_W), .DEPTH(MAX_IDS)) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_wa),
      .wr_data (ring_wd),
      .rd_en   (ring_re),
      .rd_addr (ring_ra),
      .rd_data (ring_rd)
   );

   oipa_ram #(.WIDTH(ID_W), .DEPTH(NUM_OWNERS * MAX_IDS)) u_owner_ids (
      .clock   (clock),
      .wr_en   (ids_we),
      .wr_addr (ids_wa),
      .wr_data (ring_data),
      .rd_en   (ids_re),
      .rd_addr (ids_ra),
      .rd_data (ids_rd)
   );

   oipa_ram #(.WIDTH(CNT_W), .DEPTH(NUM_OWNERS)) u_owner_len (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (own_idx),
      .wr_data (len_wd),
      .rd_en   (len_re),
      .rd_addr (own_idx),
      .rd_data (len_rd)
   );

   assign stat.cmd      = cmd_ff;
   assign stat.at_bound = (idx_ff == bound_ff);
   assign stat.idx_zero = (idx_ff == '0);
   assign stat.idx_last = ((idx_ff + CNT_W'(1)) == bound_ff);

   assign rsp_strobe   = rsp_vld_ff;
   assign rsp_status   = rsp_st_ff;
   assign rsp_answer   = rsp_ans_ff;
   assign rsp_id_out   = rsp_id_ff;
   assign rsp_id_valid = rsp_idv_ff;
   assign rsp_last     = rsp_last_ff;

   `OIPA_ASSERT_NOW(a_count_range, 1'b1, count_ff <= CNT_W'(MAX_IDS),
      "free count above pool size")
   `OIPA_ASSERT_NOW(a_id_status_ok, rsp_vld_ff && rsp_idv_ff, rsp_st_ff == ST_OK,
      "id delivered with error status")
   `OIPA_ASSERT_NEXT(a_push_grows, ctl.rel_push && ring_has_room,
      count_ff == $past(count_ff) + CNT_W'(1),
      "release push did not grow free count")

endmodule

// ===== src/owned_id_pool_allocator.sv =====
// ---------------------------------------------------------------------------
// owned_id_pool_allocator
// pool of small ids in a double-ended free ring plus an ordered id list per
// owner; command driven, one or more results per item
//
//   channel  ports                                  handshake
//   req      req_command req_owner req_id_in        start & !busy
//            req_needed_count
//   rsp      rsp_status rsp_answer rsp_id_out       rsp_strobe, one cycle
//            rsp_id_valid rsp_last
//
// single-result commands pass through the fetch, execute and response states
// before the registered result strobe; release does one ram read and one ring
// push per id the owner holds; list reads each id before issuing it as a
// result; is_free does one ring read and compare per free entry
// synchronous reset; the ring and owner lengths use valid bits, so the block
// is ready in the cycle after reset with no clearing pass
// results cannot be stalled; busy stays high until the last result is issued
// ---------------------------------------------------------------------------
module owned_id_pool_allocator
   import oipa_pkg::*;
#(
   parameter int MAX_IDS    = DEF_MAX_IDS,
   parameter int NUM_OWNERS = DEF_NUM_OWNERS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [OWNER_W-1:0]  req_owner,
   input  logic [ID_W-1:0]     req_id_in,
   input  logic [NEED_W-1:0]   req_needed_count,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_answer,
   output logic [ID_W-1:0]     rsp_id_out,
   output logic                rsp_id_valid,
   output logic                rsp_last
);

   oipa_ctl_type  ctl;
   oipa_stat_type stat;

   oipa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctl   (ctl),
      .stat  (stat)
   );

   oipa_dp #(
      .MAX_IDS    (MAX_IDS),
      .NUM_OWNERS (NUM_OWNERS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .stat             (stat),
      .req_command      (req_command),
      .req_owner        (req_owner),
      .req_id_in        (req_id_in),
      .req_needed_count (req_needed_count),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_answer       (rsp_answer),
      .rsp_id_out       (rsp_id_out),
      .rsp_id_valid     (rsp_id_valid),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== verif/tb_owned_id_pool_allocator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_owned_id_pool_allocator
// drives command items into the id pool allocator and checks every result
// against a cycle-free model of the free ring and the per-owner id lists;
// a short directed opening is followed by random command sequences that fill,
// drain and overfill the pool, with random bursts and gaps on the sender
// ---------------------------------------------------------------------------
module tb_owned_id_pool_allocator;
   import oipa_pkg::*;

   localparam int POOL_IDS    = DEF_MAX_IDS;
   localparam int POOL_OWNERS = DEF_NUM_OWNERS;
   localparam int ITEM_TARGET = 480;
   localparam int TAIL_CYCLES = 40;
   localparam int MAX_REPORTS = 10;
   localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 4'd10;
   localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 4'd15;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [OWNER_W-1:0] owner;
      logic [ID_W-1:0]    id_in;
      logic [NEED_W-1:0]  needed_count;
   } pool_cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                answer;
      logic [ID_W-1:0]     id_out;
      logic                id_valid;
      logic                last;
   } pool_reply_type;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                start            = 1'b0;
   logic                busy;
   logic [CMD_W-1:0]    req_command      = '0;
   logic [OWNER_W-1:0]  req_owner        = '0;
   logic [ID_W-1:0]     req_id_in        = '0;
   logic [NEED_W-1:0]   req_needed_count = '0;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_answer;
   logic [ID_W-1:0]     rsp_id_out;
   logic                rsp_id_valid;
   logic                rsp_last;

   pool_cmd_type   queued_cmds[$];
   pool_reply_type awaited_replies[$];
   pool_cmd_type   next_cmd;
   pool_reply_type seen_reply;

   // free ring and owner lists as the block should hold them
   logic [ID_W-1:0] ring_ids [POOL_IDS];
   int              ring_front;
   int              ids_free;
   bit              pool_is_open;
   logic [ID_W-1:0] held_ids [POOL_OWNERS][POOL_IDS];
   int              held_len [POOL_OWNERS];

   int cmds_accepted    = 0;
   int replies_checked  = 0;
   int mismatches       = 0;
   int refused_reserves = 0;
   int dropped_pushes   = 0;
   int burst_left       = 0;
   int gap_left         = 0;

   owned_id_pool_allocator #(
      .MAX_IDS    (POOL_IDS),
      .NUM_OWNERS (POOL_OWNERS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_owner        (req_owner),
      .req_id_in        (req_id_in),
      .req_needed_count (req_needed_count),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_answer       (rsp_answer),
      .rsp_id_out       (rsp_id_out),
      .rsp_id_valid     (rsp_id_valid),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [OWNER_W-1:0] rnd_owner();
      return OWNER_W'($urandom_range(0, POOL_OWNERS - 1));
   endfunction

   function automatic logic [ID_W-1:0] rnd_id();
      return ID_W'($urandom_range(0, 15));
   endfunction

   function automatic logic [NEED_W-1:0] rnd_need();
      return NEED_W'($urandom_range(0, 31));
   endfunction

   function automatic void queue_cmd(input logic [CMD_W-1:0] cmd, input logic [OWNER_W-1:0] own,
                                     input logic [ID_W-1:0] id, input logic [NEED_W-1:0] need);
      pool_cmd_type c;
      c           = '{cmd, own, id, need};
      queued_cmds = {queued_cmds, c};
   endfunction

   function automatic void add_reply(input logic [STATUS_W-1:0] st, input logic ans,
                                     input logic [ID_W-1:0] id, input logic vld,
                                     input logic lst);
      pool_reply_type r;
      if (st == ST_EMPTY) refused_reserves++;
      if (st == ST_FULL) dropped_pushes++;
      r               = '{st, ans, id, vld, lst};
      awaited_replies = {awaited_replies, r};
   endfunction

   function automatic bit take_front(output logic [ID_W-1:0] id);
      id = '0;
      if (ids_free == 0) return 1'b0;
      id = ring_ids[ring_front];
      ring_front = (ring_front + 1) % POOL_IDS;
      ids_free--;
      return 1'b1;
   endfunction

   function automatic void apply_pool_command(input pool_cmd_type c);
      logic [ID_W-1:0]     id;
      logic [STATUS_W-1:0] st;
      bit                  hit;
      bit                  own_ok;
      int                  n;
      int                  i;
      id     = '0;
      st     = ST_OK;
      hit    = 1'b0;
      own_ok = int'(c.owner) < POOL_OWNERS;
      n      = 0;
      case (c.command)
         CMD_CAN_ACCEPT:
            add_reply(ST_OK, pool_is_open && ids_free >= int'(c.needed_count), '0,
                      1'b0, 1'b1);
         CMD_CLOSE: begin
            pool_is_open = 1'b0;
            add_reply(ST_OK, 1'b0, '0, 1'b0, 1'b1);
         end
         CMD_OPEN: begin
            pool_is_open = 1'b1;
            add_reply(ST_OK, 1'b0, '0, 1'b0, 1'b1);
         end
         CMD_RESERVE_OWNED: begin
            if (own_ok && held_len[c.owner] < POOL_IDS) hit = take_front(id);
            if (hit) begin
               held_ids[c.owner][held_len[c.owner]] = id;
               held_len[c.owner]++;
               add_reply(ST_OK, 1'b0, id, 1'b1, 1'b1);
            end else begin
               add_reply(ST_EMPTY, 1'b0, '0, 1'b0, 1'b1);
            end
         end
         CMD_RELEASE_OWNER: begin
            if (own_ok) begin
               // pushed last to first so the ids leave the ring in their old order
               for (i = held_len[c.owner] - 1; i >= 0; i--) begin
                  if (ids_free >= POOL_IDS) begin
                     st = ST_FULL;
                  end else begin
                     ring_front = (ring_front + POOL_IDS - 1) % POOL_IDS;
                     ring_ids[ring_front] = held_ids[c.owner][i];
                     ids_free++;
                  end
               end
               held_len[c.owner] = 0;
            end
            add_reply(st, 1'b0, '0, 1'b0, 1'b1);
         end
         CMD_LIST_OWNER: begin
            n = own_ok ? held_len[c.owner] : 0;
            if (n > LIST_LIMIT) n = LIST_LIMIT;
            if (n == 0) begin
               add_reply(ST_OK, 1'b0, '0, 1'b0, 1'b1);
            end else begin
               for (i = 0; i < n; i++)
                  add_reply(ST_OK, 1'b0, held_ids[c.owner][i], 1'b1, i == n - 1);
            end
         end
         CMD_ANY_FREE:
            add_reply(ST_OK, ids_free > 0, '0, 1'b0, 1'b1);
         CMD_RESERVE_PLAIN: begin
            if (take_front(id)) add_reply(ST_OK, 1'b0, id, 1'b1, 1'b1);
            else add_reply(ST_EMPTY, 1'b0, '0, 1'b0, 1'b1);
         end
         CMD_GIVE_BACK: begin
            if (ids_free >= POOL_IDS) begin
               st = ST_FULL;
            end else begin
               ring_ids[(ring_front + ids_free) % POOL_IDS] = c.id_in;
               ids_free++;
            end
            add_reply(st, 1'b0, '0, 1'b0, 1'b1);
         end
         CMD_IS_FREE: begin
            for (i = 0; i < ids_free; i++)
               if (ring_ids[(ring_front + i) % POOL_IDS] == c.id_in) hit = 1'b1;
            add_reply(ST_OK, hit, '0, 1'b0, 1'b1);
         end
         default:
            add_reply(ST_OK, 1'b0, '0, 1'b0, 1'b1);
      endcase
   endfunction

   function automatic void report_mismatch(input string what, input pool_reply_type want,
                                           input pool_reply_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t %s: expected status=%0d answer=%0d id=%0d valid=%0d last=%0d,",
                  $realtime, what, want.status, want.answer, want.id_out, want.id_valid,
                  want.last,
                  " got status=%0d answer=%0d id=%0d valid=%0d last=%0d",
                  got.status, got.answer, got.id_out, got.id_valid, got.last);
   endfunction

   // driver: bursts of items with random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            apply_pool_command('{req_command, req_owner, req_id_in, req_needed_count});
            cmds_accepted++;
         end
         if (start && busy) begin
            // hold the item until it is taken
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (queued_cmds.size() > 0) begin
            next_cmd = queued_cmds[0];
            queued_cmds.delete(0);
            req_command      <= next_cmd.command;
            req_owner        <= next_cmd.owner;
            req_id_in        <= next_cmd.id_in;
            req_needed_count <= next_cmd.needed_count;
            start            <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                        : $urandom_range(0, 8);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobed result against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         seen_reply = '{rsp_status, rsp_answer, rsp_id_out, rsp_id_valid, rsp_last};
         if (awaited_replies.size() == 0) begin
            report_mismatch("result with nothing pending", '0, seen_reply);
         end else begin
            if (seen_reply !== awaited_replies[0])
               report_mismatch("result mismatch", awaited_replies[0], seen_reply);
            awaited_replies.delete(0);
            replies_checked++;
         end
      end
   end

   initial begin
      int                 roll;
      int                 pick;
      logic [OWNER_W-1:0] own;
      int                 k;
      for (k = 0; k < POOL_IDS; k++) ring_ids[k] = k[ID_W-1:0];
      for (k = 0; k < POOL_OWNERS; k++) held_len[k] = 0;
      ring_front   = 0;
      ids_free     = POOL_IDS;
      pool_is_open = 1'b1;

      // directed opening
      queue_cmd(CMD_CAN_ACCEPT, '0, '0, 5'd16);
      queue_cmd(CMD_CAN_ACCEPT, '0, '0, 5'd17);
      queue_cmd(CMD_CAN_ACCEPT, '0, '0, 5'd31);
      queue_cmd(CMD_ANY_FREE, '0, '0, '0);
      queue_cmd(CMD_GIVE_BACK, '0, 4'd15, '0);
      queue_cmd(CMD_IS_FREE, '0, 4'd15, '0);
      queue_cmd(CMD_CLOSE, '0, '0, '0);
      queue_cmd(CMD_CAN_ACCEPT, '0, '0, 5'd0);
      queue_cmd(CMD_RESERVE_OWNED, 4'd15, '0, '0);
      queue_cmd(CMD_RESERVE_OWNED, 4'd15, '0, '0);
      queue_cmd(CMD_RESERVE_PLAIN, '0, '0, '0);
      queue_cmd(CMD_OPEN, '0, '0, '0);
      queue_cmd(CMD_CAN_ACCEPT, '0, '0, 5'd13);
      queue_cmd(CMD_LIST_OWNER, 4'd15, '0, '0);
      queue_cmd(CMD_LIST_OWNER, 4'd0, '0, '0);
      queue_cmd(CMD_IS_FREE, '0, 4'd0, '0);
      queue_cmd(CMD_GIVE_BACK, '0, 4'd2, '0);
      queue_cmd(CMD_GIVE_BACK, '0, 4'd15, '0);
      queue_cmd(CMD_GIVE_BACK, '0, 4'd9, '0);
      queue_cmd(CMD_RELEASE_OWNER, 4'd15, '0, '0);
      queue_cmd(CMD_LIST_OWNER, 4'd15, '0, '0);
      queue_cmd(CMD_UNKNOWN_LO, '0, '0, '0);
      queue_cmd(CMD_UNKNOWN_HI, 4'd15, 4'd15, 5'd31);

      // random sequences
      while (queued_cmds.size() < ITEM_TARGET) begin
         roll = $urandom_range(0, 99);
         own  = rnd_owner();
         if (roll < 12) begin
            repeat ($urandom_range(1, POOL_IDS + 2))
               queue_cmd(CMD_RESERVE_OWNED, own, rnd_id(), rnd_need());
            queue_cmd(CMD_LIST_OWNER, own, rnd_id(), rnd_need());
         end else if (roll < 17) begin
            // refill, give one owner every id, then push its list past full
            queue_cmd(CMD_RELEASE_OWNER, own, rnd_id(), rnd_need());
            repeat (POOL_IDS)
               queue_cmd(CMD_GIVE_BACK, rnd_owner(), rnd_id(), rnd_need());
            repeat (POOL_IDS)
               queue_cmd(CMD_RESERVE_OWNED, own, rnd_id(), rnd_need());
            queue_cmd(CMD_GIVE_BACK, own, rnd_id(), rnd_need());
            queue_cmd(CMD_RESERVE_OWNED, own, rnd_id(), rnd_need());
            queue_cmd(CMD_LIST_OWNER, own, rnd_id(), rnd_need());
            queue_cmd(CMD_RELEASE_OWNER, own, rnd_id(), rnd_need());
            queue_cmd(CMD_IS_FREE, own, rnd_id(), rnd_need());
         end else if (roll < 27) begin
            queue_cmd(CMD_RELEASE_OWNER, own, rnd_id(), rnd_need());
            queue_cmd(CMD_LIST_OWNER, own, rnd_id(), rnd_need());
            queue_cmd(CMD_IS_FREE, own, rnd_id(), rnd_need());
            queue_cmd(CMD_CAN_ACCEPT, own, rnd_id(), NEED_W'($urandom_range(0, 16)));
         end else if (roll < 34) begin
            repeat ($urandom_range(1, POOL_IDS + 1))
               queue_cmd(CMD_RESERVE_PLAIN, own, rnd_id(), rnd_need());
            queue_cmd(CMD_ANY_FREE, own, rnd_id(), rnd_need());
         end else if (roll < 42) begin
            repeat ($urandom_range(1, 5))
               queue_cmd(CMD_GIVE_BACK, own, rnd_id(), rnd_need());
            queue_cmd(CMD_IS_FREE, own, rnd_id(), rnd_need());
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 18)
               queue_cmd(CMD_RESERVE_OWNED, own, rnd_id(), rnd_need());
            else if (pick < 30)
               queue_cmd(CMD_RELEASE_OWNER, own, rnd_id(), rnd_need());
            else if (pick < 42)
               queue_cmd(CMD_LIST_OWNER, own, rnd_id(), rnd_need());
            else if (pick < 52)
               queue_cmd(CMD_GIVE_BACK, own, rnd_id(), rnd_need());
            else if (pick < 62)
               queue_cmd(CMD_IS_FREE, own, rnd_id(), rnd_need());
            else if (pick < 70)
               queue_cmd(CMD_CAN_ACCEPT, own, rnd_id(),
                         ($urandom_range(0, 1) == 0) ? NEED_W'($urandom_range(0, 16))
                                                     : rnd_need());
            else if (pick < 76)
               queue_cmd(CMD_ANY_FREE, own, rnd_id(), rnd_need());
            else if (pick < 84)
               queue_cmd(CMD_RESERVE_PLAIN, own, rnd_id(), rnd_need());
            else if (pick < 88)
               queue_cmd(CMD_CLOSE, own, rnd_id(), rnd_need());
            else if (pick < 95)
               queue_cmd(CMD_OPEN, own, rnd_id(), rnd_need());
            else
               queue_cmd(CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI)), own,
                         rnd_id(), rnd_need());
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (queued_cmds.size() != 0 || start || awaited_replies.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d commands and checked %0d results, %0d mismatches",
               cmds_accepted, replies_checked, mismatches);
      $display("%0d reserves refused (empty ring or full owner list), %0d pushes dropped",
               refused_reserves, dropped_pushes);
      if (mismatches == 0 && awaited_replies.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("timeout with %0d results still pending", awaited_replies.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== owned_id_pool_allocator.f =====
+incdir+src
src/oipa_pkg.sv
src/oipa_ram.sv
src/oipa_ctrl.sv
src/oipa_dp.sv
src/owned_id_pool_allocator.sv
verif/tb_owned_id_pool_allocator.sv
